FILE: sv/proportional_word_wrap_assert.svh
// ----------------------------------------------------------------------------
// proportional word wrap assertion macros
// shared property wrappers, clocked on clk and held off during reset
// ----------------------------------------------------------------------------
`ifndef PROPORTIONAL_WORD_WRAP_ASSERT_SVH
`define PROPORTIONAL_WORD_WRAP_ASSERT_SVH

// same-cycle implication
`define PWW_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pww assertion failed");

// next-cycle implication
`define PWW_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pww assertion failed");

`endif

FILE: sv/pww_pkg.sv
// ----------------------------------------------------------------------------
// pww_pkg
// shared types and constants of the proportional word wrap block
// ----------------------------------------------------------------------------
package pww_pkg;

	localparam int GLYPH_COUNT  = 256;
	localparam int GLYPH_AW     = $clog2(GLYPH_COUNT);
	localparam int INDEX_BITS   = 16;
	localparam int ADVANCE_BITS = 8;
	localparam int WIDTH_BITS   = 16;
	localparam int RUN_BITS     = WIDTH_BITS + 1;
	localparam int FQ_DEPTH     = 4;
	localparam int FQ_AW        = $clog2(FQ_DEPTH);
	localparam int OQ_DEPTH     = 4;
	localparam int OQ_AW        = $clog2(OQ_DEPTH);

	localparam logic [7:0] SPACE_CODE = 8'h20;

	typedef enum logic {
		OP_LOAD = 1'b0,
		OP_CHAR = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		KIND_BREAK = 2'd0,
		KIND_DONE  = 2'd1,
		KIND_ERROR = 2'd2
	} kind_t;

	typedef logic [ADVANCE_BITS-1:0] adv_t;
	typedef logic [INDEX_BITS-1:0]   idx_t;
	typedef logic [RUN_BITS-1:0]     run_t;

	// classified input word
	typedef struct packed {
		op_t        op;
		logic       in_range;
		logic       is_space;
		logic [7:0] glyph;
		logic [7:0] advance;
		logic       last;
	} item_t;

	// one result word
	typedef struct packed {
		kind_t       kind;
		logic [15:0] break_index;
		logic [15:0] line_total;
		logic        is_last;
	} res_t;

endpackage

FILE: sv/pww_front.sv
// ----------------------------------------------------------------------------
// pww_front
// accepts input words, classifies them and holds them in a short queue
// ----------------------------------------------------------------------------
module pww_front import pww_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // glyph, advance
	input  logic        s_axis_tuser,   // op
	input  logic        s_axis_tlast,
	output logic        head_valid,
	output item_t       head,
	input  logic        head_pop
);

	item_t             fq_q [FQ_DEPTH];
	logic [FQ_AW-1:0]  wr_q;
	logic [FQ_AW-1:0]  rd_q;
	logic [FQ_AW:0]    cnt_q;
	logic              push;
	item_t             cls;

	assign s_axis_tready = (cnt_q != (FQ_AW+1)'(FQ_DEPTH));
	assign push          = s_axis_tvalid && s_axis_tready;
	assign head_valid    = (cnt_q != '0);
	assign head          = fq_q[rd_q];

	always_comb begin
		cls.op       = op_t'(s_axis_tuser);
		cls.glyph    = s_axis_tdata[7:0];
		cls.advance  = s_axis_tdata[15:8];
		cls.last     = s_axis_tlast;
		cls.is_space = (s_axis_tdata[7:0] == SPACE_CODE);
		cls.in_range = ({1'b0, s_axis_tdata[7:0]} < 9'(GLYPH_COUNT));
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fq_q[wr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (head_pop) begin
				rd_q <= rd_q + 1'b1;
			end
			case ({push, head_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

FILE: sv/pww_back.sv
// ----------------------------------------------------------------------------
// pww_back
// advance table, line state and result queue
// ----------------------------------------------------------------------------
`include "proportional_word_wrap_assert.svh"

module pww_back import pww_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [WIDTH_BITS-1:0] line_width,
	input  logic                  head_valid,
	input  item_t                 head,
	output logic                  head_pop,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [31:0]           m_axis_tdata,   // break_index, line_total
	output logic [1:0]            m_axis_tuser,   // kind
	output logic                  m_axis_tlast
);

	adv_t              mem [GLYPH_COUNT];
	logic              vld_q [GLYPH_COUNT];
	logic [GLYPH_AW-1:0] addr;

	item_t             item_s2;
	adv_t              rd_s2;
	logic              vld_s2;
	logic              valid_s2;
	logic              fire_s2;
	logic              adv_en;

	run_t              run_q;
	idx_t              sidx_q;
	run_t              wts_q;
	logic              seen_q;
	idx_t              char_q;
	idx_t              lc_q;
	logic              err_q;

	run_t              run_d;
	idx_t              sidx_d;
	run_t              wts_d;
	logic              seen_d;
	idx_t              char_d;
	idx_t              lc_d;
	logic              err_d;
	res_t              res0;
	res_t              res1;
	logic [1:0]        nres;

	res_t              oq_q [OQ_DEPTH];
	logic [OQ_AW-1:0]  oq_wr_q;
	logic [OQ_AW-1:0]  oq_rd_q;
	logic [OQ_AW:0]    oq_cnt_q;
	logic              oq_pop;

	assign addr     = head.glyph[GLYPH_AW-1:0];
	assign fire_s2  = valid_s2 && (oq_cnt_q <= (OQ_AW+1)'(OQ_DEPTH - 2));
	assign adv_en   = !valid_s2 || fire_s2;
	assign head_pop = head_valid && adv_en;

	// table write and read
	always_ff @(posedge clk) begin
		if (head_pop) begin
			if (head.op == OP_LOAD && head.in_range) begin
				mem[addr] <= ADVANCE_BITS'(head.advance);
			end
			rd_s2   <= mem[addr];
			vld_s2  <= vld_q[addr];
			item_s2 <= head;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < GLYPH_COUNT; i++) begin
				vld_q[i] <= 1'b0;
			end
			valid_s2 <= 1'b0;
		end else begin
			if (head_pop && head.op == OP_LOAD && head.in_range) begin
				vld_q[addr] <= 1'b1;
			end
			if (adv_en) begin
				valid_s2 <= head_valid;
			end
		end
	end

	// line state update
	always_comb begin
		run_t adv;
		run_t rw;
		run_t rw2;
		run_t lw;
		idx_t idx;
		logic fail;
		logic at_cur;
		logic clr;

		adv    = (vld_s2 && item_s2.in_range) ? RUN_BITS'(rd_s2) : '0;
		lw     = RUN_BITS'(line_width);
		idx    = char_q;
		rw     = run_q + adv;
		rw2    = '0;
		fail   = 1'b0;
		at_cur = 1'b0;
		clr    = 1'b0;

		run_d  = run_q;
		sidx_d = sidx_q;
		wts_d  = wts_q;
		seen_d = seen_q;
		char_d = char_q;
		lc_d   = lc_q;
		err_d  = err_q;
		nres   = 2'd0;
		res0   = '{kind: KIND_BREAK, break_index: '0, line_total: '0, is_last: 1'b0};
		res1   = res0;

		if (item_s2.op == OP_CHAR) begin
			if (err_q) begin
				clr = item_s2.last;
			end else begin
				char_d = idx + 1'b1;
				run_d  = rw;
				if (item_s2.is_space && rw <= lw) begin
					seen_d = 1'b1;
					sidx_d = idx;
					wts_d  = rw;
				end
				if (rw >= lw) begin
					if (seen_d) begin
						at_cur = (sidx_d == idx);
						if (lc_q != '1) begin
							lc_d = lc_q + 1'b1;
						end
						res0.kind        = KIND_BREAK;
						res0.break_index = 16'(sidx_d);
						res0.line_total  = 16'(lc_d);
						nres             = 2'd1;
						rw2    = rw - wts_d;
						run_d  = rw2;
						seen_d = 1'b0;
						wts_d  = '0;
						if (!at_cur && rw2 >= lw) begin
							if (item_s2.is_space && rw2 == lw) begin
								seen_d = 1'b1;
								sidx_d = idx;
								wts_d  = rw2;
							end else begin
								fail = 1'b1;
							end
						end
					end else begin
						fail = 1'b1;
					end
				end
				if (fail || item_s2.last) begin
					if (nres == 2'd1) begin
						res1.kind        = fail ? KIND_ERROR : KIND_DONE;
						res1.break_index = '0;
						res1.line_total  = 16'(lc_d);
						nres             = 2'd2;
					end else begin
						res0.kind        = fail ? KIND_ERROR : KIND_DONE;
						res0.break_index = '0;
						res0.line_total  = 16'(lc_d);
						nres             = 2'd1;
					end
					if (item_s2.last) begin
						clr = 1'b1;
					end else begin
						err_d = 1'b1;
					end
				end
				res0.is_last = (nres == 2'd1);
				res1.is_last = (nres == 2'd2);
			end
		end

		if (clr) begin
			run_d  = '0;
			sidx_d = '0;
			wts_d  = '0;
			seen_d = 1'b0;
			char_d = '0;
			lc_d   = idx_t'(1);
			err_d  = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= '0;
			sidx_q <= '0;
			wts_q  <= '0;
			seen_q <= 1'b0;
			char_q <= '0;
			lc_q   <= idx_t'(1);
			err_q  <= 1'b0;
		end else if (fire_s2) begin
			run_q  <= run_d;
			sidx_q <= sidx_d;
			wts_q  <= wts_d;
			seen_q <= seen_d;
			char_q <= char_d;
			lc_q   <= lc_d;
			err_q  <= err_d;
		end
	end

	// result queue
	assign m_axis_tvalid = (oq_cnt_q != '0);
	assign oq_pop        = m_axis_tvalid && m_axis_tready;
	assign m_axis_tdata  = {oq_q[oq_rd_q].line_total, oq_q[oq_rd_q].break_index};
	assign m_axis_tuser  = oq_q[oq_rd_q].kind;
	assign m_axis_tlast  = oq_q[oq_rd_q].is_last;

	always_ff @(posedge clk) begin
		if (fire_s2 && nres != 2'd0) begin
			oq_q[oq_wr_q] <= res0;
		end
		if (fire_s2 && nres == 2'd2) begin
			oq_q[oq_wr_q + 1'b1] <= res1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oq_wr_q  <= '0;
			oq_rd_q  <= '0;
			oq_cnt_q <= '0;
		end else begin
			if (fire_s2) begin
				oq_wr_q <= oq_wr_q + OQ_AW'(nres);
			end
			if (oq_pop) begin
				oq_rd_q <= oq_rd_q + 1'b1;
			end
			oq_cnt_q <= oq_cnt_q + (fire_s2 ? (OQ_AW+1)'(nres) : '0)
				- (OQ_AW+1)'(oq_pop);
		end
	end

	`PWW_ASSERT_NOW(a_oq_bound, 1'b1, oq_cnt_q <= (OQ_AW+1)'(OQ_DEPTH))
	`PWW_ASSERT_NOW(a_lc_nonzero, 1'b1, lc_q != '0)
	`PWW_ASSERT_NOW(a_err_no_cand, err_q, !seen_q)
	`PWW_ASSERT_NEXT(a_two_res_room, fire_s2 && nres == 2'd2, oq_cnt_q >= (OQ_AW+1)'(2))

endmodule

FILE: sv/proportional_word_wrap.sv
// ----------------------------------------------------------------------------
// proportional_word_wrap
// greedy word wrap over a loadable table of glyph advance widths
//
// channel   dir  tdata                         tuser  tlast
// s_axis    in   glyph[7:0], advance[15:8]     op     last_char
// m_axis    out  break_index[15:0],            kind   is_last
//                line_total[31:16]
// config    in   line_width_wdata, written when line_width_we is high
//
// one word per cycle while the result queue has room for two; the line state
// update (add, compare, subtract, compare) in the back stage sets this figure
// words that give two results write both into the result queue together
// words pass from the input queue via the back stage into the result queue
// reset clears the advance table at once through per-entry valid bits
// a four-entry queue on each side lets input and output stall on their own
// ----------------------------------------------------------------------------
module proportional_word_wrap import pww_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        line_width_we,
	input  logic [15:0] line_width_wdata,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // glyph, advance
	input  logic        s_axis_tuser,   // op
	input  logic        s_axis_tlast,   // last_char
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // break_index, line_total
	output logic [1:0]  m_axis_tuser,   // kind
	output logic        m_axis_tlast    // is_last
);

	logic [WIDTH_BITS-1:0] line_width_q;
	logic                  head_valid;
	item_t                 head;
	logic                  head_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_width_q <= '0;
		end else if (line_width_we) begin
			line_width_q <= line_width_wdata;
		end
	end

	pww_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.head_valid    (head_valid),
		.head          (head),
		.head_pop      (head_pop)
	);

	pww_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.line_width    (line_width_q),
		.head_valid    (head_valid),
		.head          (head),
		.head_pop      (head_pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule
